### rtl/core/assert_macros.svh
// Assertion macros for the checker module of this project.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, idle in reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, idle in reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/ohlc_pkg.sv
// Package for the OHLC candle aggregator: item and candle types, codes, constants.
// No dependencies; the store, update unit and aggregator refer to it by scoped names.
package ohlc_pkg;

    // Field widths fixed by the item formats.
    localparam int SYM_W   = 10;
    localparam int PX_W    = 32;
    localparam int QTY_W   = 32;
    localparam int TIME_W  = 64;
    localparam int VOL_W   = 64;
    localparam int WIN_W   = 17;
    localparam int NS_W    = 30;
    localparam int LIMIT_W = WIN_W + NS_W;

    localparam int NUM_WINDOWS     = 3;
    localparam int NUM_SYMBOLS_DEF = 1024;

    localparam logic [NS_W-1:0] NS_PER_SEC = NS_W'(1_000_000_000);

    // Window selector codes, in emission priority order.
    localparam logic [1:0] WIN_SHORT = 2'd0;
    localparam logic [1:0] WIN_MID   = 2'd1;
    localparam logic [1:0] WIN_LONG  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SHORT_WIN = 2'd0;
    localparam logic [1:0] CFG_MID_WIN   = 2'd1;
    localparam logic [1:0] CFG_LONG_WIN  = 2'd2;

    // Window lengths after reset, in seconds.
    localparam logic [WIN_W-1:0] SHORT_WIN_RST = WIN_W'(60);
    localparam logic [WIN_W-1:0] MID_WIN_RST   = WIN_W'(300);
    localparam logic [WIN_W-1:0] LONG_WIN_RST  = WIN_W'(900);

    // One input item: a trade.
    typedef struct packed {
        logic [SYM_W-1:0]  symbol_index;
        logic [PX_W-1:0]   trade_price;
        logic [QTY_W-1:0]  trade_quantity;
        logic [TIME_W-1:0] trade_time_ns;
    } t_trade;

    // One result item: a closed candle.
    typedef struct packed {
        logic [SYM_W-1:0]  closed_symbol;
        logic [WIN_W-1:0]  closed_window_seconds;
        logic [PX_W-1:0]   open_price;
        logic [PX_W-1:0]   high_price;
        logic [PX_W-1:0]   low_price;
        logic [PX_W-1:0]   close_price;
        logic [VOL_W-1:0]  total_volume;
        logic [TIME_W-1:0] open_time_ns;
    } t_result;

    // One stored candle; the symbol is implied by the store address.
    typedef struct packed {
        logic [TIME_W-1:0] t_open;
        logic [VOL_W-1:0]  vol;
        logic [PX_W-1:0]   px_open;
        logic [PX_W-1:0]   px_high;
        logic [PX_W-1:0]   px_low;
        logic [PX_W-1:0]   px_close;
        logic [WIN_W-1:0]  win;
    } t_candle;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } t_state;

endpackage

### rtl/core/ohlc_store.sv
// Candle store: one write port and one registered read port.
// Depends on ohlc_pkg for the candle type.
module ohlc_store #(
    parameter int DEPTH = 3 * ohlc_pkg::NUM_SYMBOLS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [AW-1:0]          i_waddr,
    input  ohlc_pkg::t_candle      i_wdata,
    input  logic [AW-1:0]          i_raddr,
    output ohlc_pkg::t_candle      o_rdata
);

    ohlc_pkg::t_candle r_mem [DEPTH];
    ohlc_pkg::t_candle r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/ohlc_upd.sv
// Shared candle update unit, used once per window under the sequencer.
// Depends on ohlc_pkg for the trade and candle types.
module ohlc_upd (
    input  ohlc_pkg::t_candle                 i_candle,
    input  ohlc_pkg::t_trade                  i_trade,
    input  logic [ohlc_pkg::LIMIT_W-1:0]      i_limit,
    input  logic [ohlc_pkg::WIN_W-1:0]        i_win_len,
    output ohlc_pkg::t_candle                 o_candle,
    output logic                              o_closed
);

    logic                          is_empty;
    logic                          is_inside;
    logic [ohlc_pkg::TIME_W-1:0]   elapsed;
    logic [ohlc_pkg::VOL_W-1:0]    qty_ext;

    // Elapsed time wraps modulo 2^64; the candle is live while it is below the limit.
    assign is_empty  = (i_candle.t_open == '0);
    assign elapsed   = i_trade.trade_time_ns - i_candle.t_open;
    assign is_inside = (elapsed < ohlc_pkg::TIME_W'(i_limit));
    assign qty_ext   = ohlc_pkg::VOL_W'(i_trade.trade_quantity);

    // A non-empty candle that the trade falls outside of is closed.
    assign o_closed = !is_empty && !is_inside;

    // New candle contents: reopen from the trade, or fold the trade in.
    always_comb begin
        o_candle = i_candle;
        if (is_empty || !is_inside) begin
            o_candle.t_open   = i_trade.trade_time_ns;
            o_candle.vol      = qty_ext;
            o_candle.px_open  = i_trade.trade_price;
            o_candle.px_high  = i_trade.trade_price;
            o_candle.px_low   = i_trade.trade_price;
            o_candle.px_close = i_trade.trade_price;
            o_candle.win      = i_win_len;
        end else begin
            if (i_trade.trade_price > i_candle.px_high) begin
                o_candle.px_high = i_trade.trade_price;
            end
            if (i_trade.trade_price < i_candle.px_low) begin
                o_candle.px_low = i_trade.trade_price;
            end
            o_candle.px_close = i_trade.trade_price;
            o_candle.vol      = i_candle.vol + qty_ext;
        end
    end

endmodule

### rtl/core/ohlc_candle_aggregator_unit.sv
// A result strobe, if any, comes in the output state once the item has passed all windows;
// each of the three windows takes a read state and an update state through the store
// and the shared update unit, and no new item is taken before the output state.
// An item with a symbol beyond the store returns the block to idle after its first read.
// Reset: window lengths return to 60/300/900 s, then a clearing pass writes zero to
// every store address with busy high. Results cannot be stalled.
module ohlc_candle_aggregator_unit #(
    parameter int NUM_SYMBOLS = ohlc_pkg::NUM_SYMBOLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ohlc_pkg::t_trade              i_trade,
    output logic                          o_result_valid,
    output ohlc_pkg::t_result             o_result,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [ohlc_pkg::WIN_W-1:0]    i_cfg_data
);

    localparam int DEPTH = ohlc_pkg::NUM_WINDOWS * NUM_SYMBOLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);
    localparam logic [AW-1:0] MidBase  = AW'(NUM_SYMBOLS);
    localparam logic [AW-1:0] LongBase = AW'(2 * NUM_SYMBOLS);

    ohlc_pkg::t_state                 r_state;
    ohlc_pkg::t_state                 n_state;
    logic [AW-1:0]                    r_clr_addr;
    ohlc_pkg::t_trade                 r_item;
    logic [1:0]                       r_win_sel;
    logic [ohlc_pkg::LIMIT_W-1:0]     r_limit;
    logic                             r_emitted;
    ohlc_pkg::t_result                r_result;
    logic [ohlc_pkg::WIN_W-1:0]       r_win_len [ohlc_pkg::NUM_WINDOWS];

    logic                             accept;
    logic                             sym_ok;
    logic [AW-1:0]                    win_base;
    logic [AW-1:0]                    cand_addr;
    logic [ohlc_pkg::WIN_W-1:0]       sel_len;
    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    ohlc_pkg::t_candle                mem_wdata;
    ohlc_pkg::t_candle                mem_rdata;
    ohlc_pkg::t_candle                upd_candle;
    logic                             upd_closed;

    // Store of all candles, window-major.
    ohlc_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (cand_addr),
        .o_rdata (mem_rdata)
    );

    // Shared update unit, one window per pass.
    ohlc_upd u_upd (
        .i_candle  (mem_rdata),
        .i_trade   (r_item),
        .i_limit   (r_limit),
        .i_win_len (sel_len),
        .o_candle  (upd_candle),
        .o_closed  (upd_closed)
    );

    // Window selection: store base address and current length.
    always_comb begin
        unique case (r_win_sel)
            ohlc_pkg::WIN_SHORT: begin
                win_base = '0;
                sel_len  = r_win_len[0];
            end
            ohlc_pkg::WIN_MID: begin
                win_base = MidBase;
                sel_len  = r_win_len[1];
            end
            ohlc_pkg::WIN_LONG: begin
                win_base = LongBase;
                sel_len  = r_win_len[2];
            end
            default: begin
                win_base = '0;
                sel_len  = '0;
            end
        endcase
    end

    assign sym_ok    = (32'(r_item.symbol_index) < NUM_SYMBOLS);
    assign cand_addr = win_base + AW'(r_item.symbol_index);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ohlc_pkg::ST_CLEAR: begin
                if (r_clr_addr == LastAddr) begin
                    n_state = ohlc_pkg::ST_IDLE;
                end
            end
            ohlc_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = ohlc_pkg::ST_READ;
                end
            end
            ohlc_pkg::ST_READ: begin
                n_state = sym_ok ? ohlc_pkg::ST_UPDATE : ohlc_pkg::ST_IDLE;
            end
            ohlc_pkg::ST_UPDATE: begin
                n_state = (r_win_sel == ohlc_pkg::WIN_LONG) ? ohlc_pkg::ST_OUT
                                                             : ohlc_pkg::ST_READ;
            end
            ohlc_pkg::ST_OUT: begin
                n_state = start ? ohlc_pkg::ST_READ : ohlc_pkg::ST_IDLE;
            end
            default: begin
                n_state = ohlc_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer: handshake and store write port.
    always_comb begin
        busy      = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = cand_addr;
        mem_wdata = upd_candle;
        unique case (r_state)
            ohlc_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            ohlc_pkg::ST_IDLE,
            ohlc_pkg::ST_OUT: begin
                busy = 1'b0;
            end
            ohlc_pkg::ST_UPDATE: begin
                mem_we = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign accept = start && !busy;

    // State register and clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ohlc_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ohlc_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Window lengths, written through the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len[0] <= ohlc_pkg::SHORT_WIN_RST;
            r_win_len[1] <= ohlc_pkg::MID_WIN_RST;
            r_win_len[2] <= ohlc_pkg::LONG_WIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ohlc_pkg::CFG_SHORT_WIN: r_win_len[0] <= i_cfg_data;
                ohlc_pkg::CFG_MID_WIN:   r_win_len[1] <= i_cfg_data;
                ohlc_pkg::CFG_LONG_WIN:  r_win_len[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Window step and emission flag for the item in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_sel <= ohlc_pkg::WIN_SHORT;
            r_emitted <= 1'b0;
        end else if (accept) begin
            r_win_sel <= ohlc_pkg::WIN_SHORT;
            r_emitted <= 1'b0;
        end else if (r_state == ohlc_pkg::ST_UPDATE) begin
            unique case (r_win_sel)
                ohlc_pkg::WIN_SHORT: r_win_sel <= ohlc_pkg::WIN_MID;
                ohlc_pkg::WIN_MID:   r_win_sel <= ohlc_pkg::WIN_LONG;
                default:             r_win_sel <= ohlc_pkg::WIN_SHORT;
            endcase
            if (upd_closed) begin
                r_emitted <= 1'b1;
            end
        end
    end

    // Captured trade.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_trade;
        end
    end

    // Window limit in ns, formed while the candle is read.
    always_ff @(posedge i_clk) begin
        if (r_state == ohlc_pkg::ST_READ) begin
            r_limit <= ohlc_pkg::LIMIT_W'(sel_len) * ohlc_pkg::LIMIT_W'(ohlc_pkg::NS_PER_SEC);
        end
    end

    // The first candle that closes on this item becomes the result.
    always_ff @(posedge i_clk) begin
        if ((r_state == ohlc_pkg::ST_UPDATE) && upd_closed && !r_emitted) begin
            r_result.closed_symbol         <= r_item.symbol_index;
            r_result.closed_window_seconds <= mem_rdata.win;
            r_result.open_price            <= mem_rdata.px_open;
            r_result.high_price            <= mem_rdata.px_high;
            r_result.low_price             <= mem_rdata.px_low;
            r_result.close_price           <= mem_rdata.px_close;
            r_result.total_volume          <= mem_rdata.vol;
            r_result.open_time_ns          <= mem_rdata.t_open;
        end
    end

    assign o_result_valid = (r_state == ohlc_pkg::ST_OUT) && r_emitted;
    assign o_result       = r_result;

endmodule

### rtl/core/ohlc_chk.sv
// Port-level checker for the OHLC candle aggregator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ohlc_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_result_valid
);

    logic item_taken;

    assign item_taken = start && !busy;

    // An accepted item keeps the block busy in the following cycle.
    `ASSERT_NEXT(a_busy_after_accept, item_taken, busy)

    // A result is a single-cycle strobe, never two in a row.
    `ASSERT_NEXT(a_result_single, o_result_valid, !o_result_valid)

    // A result follows the acceptance of its item and the read and update states of all windows.
    `ASSERT_SAME(a_result_latency, o_result_valid, $past(item_taken, 7))

    // A result is shown only when the block is ready for the next item.
    `ASSERT_SAME(a_result_ready, o_result_valid, !busy)

endmodule

bind ohlc_candle_aggregator_unit ohlc_chk u_ohlc_chk (.*);

### dv/ohlc_candle_aggregator_unit_tb.sv
// Self-checking testbench for the OHLC candle aggregator: trades in, closed candles out.
// Depends on ohlc_pkg and ohlc_candle_aggregator_unit; a candle book predicts closed candles
// where no directed row fixes them; a directed table and random trade bursts drive the block.
module ohlc_candle_aggregator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ohlc_pkg::*;

    // The store covers the full 10-bit symbol range.
    localparam int STORE_SYMBOLS = 1024;
    localparam int NUM_PHASES = 5;
    localparam int TRADES_PER_PHASE = 100;
    localparam logic [63:0] ONE_SEC_NS = 64'd1_000_000_000;
    localparam logic [63:0] MAX_TIME = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] MAX_PX = 32'hFFFF_FFFF;
    // Register index past the three windows; writes to it must have no effect.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [1:0] WINDOW_REGS [NUM_WINDOWS] = '{CFG_SHORT_WIN, CFG_MID_WIN, CFG_LONG_WIN};

    // How a directed item is checked.
    typedef enum logic [1:0] {
        FROM_MODEL,
        NO_CANDLE,
        FIXED_CANDLE
    } t_row_check;

    typedef struct {
        t_trade     tr;
        t_row_check chk;
        t_result    candle;
    } t_trade_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_trade     i_trade;
    logic       o_result_valid;
    t_result    o_result;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [WIN_W-1:0] i_cfg_data;

    // Predicted state: one candle per symbol and window, plus the window lengths.
    t_candle          candle_book [STORE_SYMBOLS*NUM_WINDOWS];
    logic [WIN_W-1:0] window_len [NUM_WINDOWS];
    t_result          closed_candles [$];
    t_trade_row       directed_rows [$];
    logic [63:0]      sym_clock [1024];
    int               error_count = 0;

    ohlc_candle_aggregator_unit #(
        .NUM_SYMBOLS(STORE_SYMBOLS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_trade(i_trade),
        .o_result_valid(o_result_valid),
        .o_result(o_result),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the run, far beyond the slowest legal one.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Applies one trade to the candle book and returns whether a candle is emitted.
    // Only the first window to close, in window order, reports its candle.
    function automatic bit fold_trade(input t_trade tr, output t_result closed);
        int unsigned slot;
        t_candle     bar;
        logic [63:0] limit;
        bit          emitted;
        emitted = 1'b0;
        closed = '0;
        if (tr.symbol_index >= STORE_SYMBOLS) begin
            return 1'b0;
        end
        for (int w = 0; w < NUM_WINDOWS; w++) begin
            slot = tr.symbol_index * NUM_WINDOWS + w;
            bar = candle_book[slot];
            limit = 64'(window_len[w]) * 64'(NS_PER_SEC);
            if (bar.t_open != '0 && (tr.trade_time_ns - bar.t_open) < limit) begin
                if (tr.trade_price > bar.px_high) begin
                    bar.px_high = tr.trade_price;
                end
                if (tr.trade_price < bar.px_low) begin
                    bar.px_low = tr.trade_price;
                end
                bar.px_close = tr.trade_price;
                bar.vol = bar.vol + 64'(tr.trade_quantity);
            end else begin
                // An open time of zero reads as empty: reopen without reporting.
                if (bar.t_open != '0 && !emitted) begin
                    closed.closed_symbol = tr.symbol_index;
                    closed.closed_window_seconds = bar.win;
                    closed.open_price = bar.px_open;
                    closed.high_price = bar.px_high;
                    closed.low_price = bar.px_low;
                    closed.close_price = bar.px_close;
                    closed.total_volume = bar.vol;
                    closed.open_time_ns = bar.t_open;
                    emitted = 1'b1;
                end
                bar.t_open = tr.trade_time_ns;
                bar.vol = 64'(tr.trade_quantity);
                bar.px_open = tr.trade_price;
                bar.px_high = tr.trade_price;
                bar.px_low = tr.trade_price;
                bar.px_close = tr.trade_price;
                bar.win = window_len[w];
            end
            candle_book[slot] = bar;
        end
        return emitted;
    endfunction

    function automatic void add_row(input logic [SYM_W-1:0] sym, input logic [31:0] px,
                                    input logic [31:0] qty, input logic [63:0] t,
                                    input t_row_check chk, input t_result candle);
        t_trade_row row;
        row.tr = '{sym, px, qty, t};
        row.chk = chk;
        row.candle = candle;
        directed_rows.push_back(row);
    endfunction

    // Presents one trade after a gap, waits until it is taken, then records what it closes.
    task automatic send_trade(input t_trade tr, input int gap, input t_row_check chk,
                              input t_result candle);
        t_result predicted;
        bit      emitted;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_trade <= tr;
        do @(posedge i_clk); while (busy !== 1'b0);
        emitted = fold_trade(tr, predicted);
        case (chk)
            FROM_MODEL: begin
                if (emitted) begin
                    closed_candles.push_back(predicted);
                end
            end
            FIXED_CANDLE: begin
                closed_candles.push_back(candle);
            end
            default: begin
            end
        endcase
    endtask

    // Writes all three window lengths, then a stray write to the unused index.
    task automatic set_windows(input logic [WIN_W-1:0] short_s, input logic [WIN_W-1:0] mid_s,
                               input logic [WIN_W-1:0] long_s);
        logic [WIN_W-1:0] lens [NUM_WINDOWS];
        lens = '{short_s, mid_s, long_s};
        for (int w = 0; w < NUM_WINDOWS; w++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= WINDOW_REGS[w];
            i_cfg_data <= lens[w];
            window_len[w] = lens[w];
            @(posedge i_clk);
        end
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data <= WIN_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits for every expected candle, flags any that never came, then lets the block settle.
    task automatic drain_candles();
        int waited;
        waited = 0;
        while (closed_candles.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        if (closed_candles.size() != 0) begin
            $error("%0d expected candles never came out", closed_candles.size());
            error_count++;
            closed_candles.delete();
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Every strobed result is matched against the oldest expected candle.
    always @(posedge i_clk) begin
        t_result exp_c;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (closed_candles.size() == 0) begin
                $error("unexpected candle for symbol %0d", o_result.closed_symbol);
                error_count++;
            end else begin
                exp_c = closed_candles.pop_front();
                check_field("closed_symbol", 64'(exp_c.closed_symbol), 64'(o_result.closed_symbol));
                check_field("closed_window_seconds", 64'(exp_c.closed_window_seconds),
                            64'(o_result.closed_window_seconds));
                check_field("open_price", 64'(exp_c.open_price), 64'(o_result.open_price));
                check_field("high_price", 64'(exp_c.high_price), 64'(o_result.high_price));
                check_field("low_price", 64'(exp_c.low_price), 64'(o_result.low_price));
                check_field("close_price", 64'(exp_c.close_price), 64'(o_result.close_price));
                check_field("total_volume", exp_c.total_volume, o_result.total_volume);
                check_field("open_time_ns", exp_c.open_time_ns, o_result.open_time_ns);
            end
        end
    end

    initial begin
        t_trade          tr;
        t_trade_row      row;
        logic [SYM_W-1:0] pool [4];
        logic [SYM_W-1:0] sym;
        logic [63:0]     advance;
        logic [63:0]     limit;
        int              gap;
        bit              calm;

        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_trade <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_SHORT_WIN;
        i_cfg_data <= '0;
        foreach (candle_book[k]) begin
            candle_book[k] = '0;
        end
        window_len = '{SHORT_WIN_RST, MID_WIN_RST, LONG_WIN_RST};
        foreach (sym_clock[k]) begin
            sym_clock[k] = rand64();
        end

        // Directed trades: field extremes, window edges, empty and top symbols, wrap.
        add_row(10'd5, 32'd100, 32'd10, ONE_SEC_NS, NO_CANDLE, '0);
        add_row(10'd5, MAX_PX, MAX_PX, 64'd2_000_000_000, NO_CANDLE, '0);
        add_row(10'd5, 32'd0, 32'd1, 64'd3_000_000_000, NO_CANDLE, '0);
        // Exactly one short window after the open: the short candle closes.
        add_row(10'd5, 32'd50, 32'd7, 64'd61_000_000_000, FIXED_CANDLE,
                t_result'{10'd5, 17'd60, 32'd100, MAX_PX, 32'd0, 32'd0,
                          64'h1_0000_000A, ONE_SEC_NS});
        // One nanosecond short of the window end stays inside.
        add_row(10'd5, 32'd9, 32'd3, 64'd120_999_999_999, NO_CANDLE, '0);
        // Short and mid close together; only the short candle is reported.
        add_row(10'd5, 32'd200, 32'd1, 64'd301_000_000_000, FIXED_CANDLE,
                t_result'{10'd5, 17'd60, 32'd50, 32'd50, 32'd9, 32'd9,
                          64'd10, 64'd61_000_000_000});
        // Top symbols open fresh candles at the extremes of time.
        add_row(10'd1023, MAX_PX, MAX_PX, MAX_TIME, NO_CANDLE, '0);
        add_row(10'd1000, 32'd1, 32'd1, 64'd5, NO_CANDLE, '0);
        // A candle opened at time zero still reads as empty.
        add_row(10'd0, 32'd7, 32'd7, 64'd0, NO_CANDLE, '0);
        add_row(10'd0, 32'd8, 32'd8, 64'd5_000_000_000, NO_CANDLE, '0);
        add_row(10'd0, 32'd9, 32'd9, 64'd200_000_000_000, FIXED_CANDLE,
                t_result'{10'd0, 17'd60, 32'd8, 32'd8, 32'd8, 32'd8,
                          64'd8, 64'd5_000_000_000});
        // Elapsed time wraps through zero and stays inside, then jumps nearly a full turn.
        add_row(10'd7, MAX_PX, 32'd0, MAX_TIME, NO_CANDLE, '0);
        add_row(10'd7, 32'd0, MAX_PX, 64'd5, NO_CANDLE, '0);
        add_row(10'd7, 32'd1, 32'd1, MAX_TIME - 64'd1, FIXED_CANDLE,
                t_result'{10'd7, 17'd60, MAX_PX, MAX_PX, 32'd0, 32'd0,
                          64'hFFFF_FFFF, MAX_TIME});
        // A high symbol near the top of the range.
        add_row(10'd999, 32'd3, 32'd4, 64'd1, NO_CANDLE, '0);
        add_row(10'd999, 32'd5, 32'd6, 64'd900_000_000_001, FIXED_CANDLE,
                t_result'{10'd999, 17'd60, 32'd3, 32'd3, 32'd3, 32'd3, 64'd4, 64'd1});
        add_row(10'd5, 32'd1, 32'd1, 64'd360_999_999_999, FROM_MODEL, '0);

        // Reset once, then wait out the clearing pass.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_trade(row.tr, $urandom_range(0, 5), row.chk, row.candle);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Window settings change only once the block has gone quiet.
            if (phase > 0) begin
                start <= 1'b0;
                drain_candles();
                case (phase)
                    1: set_windows(17'd1, 17'd2, 17'd3);
                    2: set_windows(17'd0, 17'd86400, 17'h1FFFF);
                    3: set_windows(17'd86400, 17'd1, 17'd0);
                    default: set_windows(WIN_W'($urandom_range(1, 86400)),
                                         WIN_W'($urandom_range(1, 86400)),
                                         WIN_W'($urandom_range(1, 86400)));
                endcase
            end
            foreach (pool[k]) begin
                pool[k] = SYM_W'($urandom_range(0, 1023));
            end
            calm = 1'b0;
            for (int n = 0; n < TRADES_PER_PHASE; n++) begin
                if (n % 20 == 0) begin
                    calm = ($urandom_range(0, 3) == 0);
                end
                gap = calm ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 99) < 15) begin
                    // Noise: any symbol, any time, now and then time zero.
                    tr.symbol_index = SYM_W'($urandom_range(0, 1023));
                    tr.trade_time_ns = ($urandom_range(0, 4) == 0) ? 64'd0 : rand64();
                end else begin
                    // A running trade stream per symbol, stepping relative to one window.
                    sym = pool[$urandom_range(0, 3)];
                    limit = 64'(window_len[$urandom_range(0, NUM_WINDOWS - 1)]) * ONE_SEC_NS;
                    if (limit == 0) begin
                        limit = ONE_SEC_NS;
                    end
                    case ($urandom_range(0, 9))
                        7, 8: advance = limit - 64'd1 + 64'($urandom_range(0, 2));
                        9: advance = rand64();
                        default: advance = rand64() % (limit / 3 + 64'd1);
                    endcase
                    sym_clock[sym] = sym_clock[sym] + advance;
                    tr.symbol_index = sym;
                    tr.trade_time_ns = sym_clock[sym];
                end
                case ($urandom_range(0, 7))
                    0: tr.trade_price = 32'd0;
                    1: tr.trade_price = MAX_PX;
                    default: tr.trade_price = $urandom;
                endcase
                case ($urandom_range(0, 7))
                    0: tr.trade_quantity = 32'd0;
                    1: tr.trade_quantity = MAX_PX;
                    default: tr.trade_quantity = $urandom;
                endcase
                send_trade(tr, gap, FROM_MODEL, '0);
            end
        end

        start <= 1'b0;
        drain_candles();
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
